@@ design/pmst_pkg.sv @@
// ----------------------------------------------------------------------------
// pmst_pkg
// Shared types and constants for the peer misbehavior score table: operation
// codes, the queued command, the table entry layout and the CSR map.
// ----------------------------------------------------------------------------
`default_nettype none

package pmst_pkg;

   // Field widths
   localparam int MODE_W    = 3;
   localparam int PEER_W    = 6;
   localparam int PENALTY_W = 10;
   localparam int SCORE_W   = 16;
   localparam int UNC_W     = 8;

   // Number of slots the peer field can address
   localparam int PEER_SPACE = 1 << PEER_W;

   // Request mode codes
   localparam logic [MODE_W-1:0] MODE_REPORT  = 3'd0;
   localparam logic [MODE_W-1:0] MODE_UNC_INC = 3'd1;
   localparam logic [MODE_W-1:0] MODE_UNC_RST = 3'd2;
   localparam logic [MODE_W-1:0] MODE_QUERY   = 3'd3;
   localparam logic [MODE_W-1:0] MODE_ATTACH  = 3'd4;
   localparam logic [MODE_W-1:0] MODE_DETACH  = 3'd5;

   // Classified operation handed from front to back
   typedef enum logic [2:0] {
      OP_REPORT,
      OP_UNC_INC,
      OP_UNC_RST,
      OP_QUERY,
      OP_ATTACH,
      OP_DETACH,
      OP_NONE        // peer index outside the table
   } op_type;

   typedef struct packed {
      op_type                 op;
      logic [PEER_W-1:0]      peer;
      logic [PENALTY_W-1:0]   penalty;
      logic                   no_ban;
   } cmd_type;

   // One table entry
   typedef struct packed {
      logic                   no_ban;
      logic [SCORE_W-1:0]     score;
      logic                   discourage;
      logic [UNC_W-1:0]       unconnecting;
      logic                   latch;
   } entry_type;

   // Configuration values seen by the back end
   typedef struct packed {
      logic [SCORE_W-1:0]     threshold;
      logic [UNC_W-1:0]       unc_limit;
      logic [PENALTY_W-1:0]   unc_penalty;
   } cfg_type;

   // CSR map (register index = paddr[3:2])
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam logic [1:0] CSR_THRESHOLD   = 2'd0;
   localparam logic [1:0] CSR_UNC_LIMIT   = 2'd1;
   localparam logic [1:0] CSR_UNC_PENALTY = 2'd2;

   localparam logic [SCORE_W-1:0]   THRESHOLD_RST   = 16'd100;
   localparam logic [UNC_W-1:0]     UNC_LIMIT_RST   = 8'd10;
   localparam logic [PENALTY_W-1:0] UNC_PENALTY_RST = 10'd20;

endpackage

`default_nettype wire

@@ design/peer_misbehavior_score_table.sv @@
// ----------------------------------------------------------------------------
// peer_misbehavior_score_table
// Per-peer misbehavior score table with threshold marking, an unconnecting
// message counter with a one-time penalty, and attach/detach of slots.
//
//   Port group   Dir      Handshake            Beat
//   req_*        in       req_valid/req_ready  mode, peer, penalty, no_ban
//   rsp_*        out      rsp_valid/rsp_ready  found, flags, score, count
//   APB          in/out   psel/penable/pready  three config registers
//
// Each request runs in the back end as a table read, then the update,
// write-back and result load. The back end finishes one request before it
// reads the next, as each is a read-modify-write of one slot table entry. A
// two-entry queue lets requests be taken while a result waits. Reset marks
// every slot absent; no clearing pass is needed. A stalled result holds the
// back end in its update step until taken.
// ----------------------------------------------------------------------------
`default_nettype none

module peer_misbehavior_score_table #(
   parameter int PEER_SLOTS = 64
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // Request channel
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [pmst_pkg::MODE_W-1:0]       req_mode,
   input  wire logic [pmst_pkg::PEER_W-1:0]       req_peer,
   input  wire logic [pmst_pkg::PENALTY_W-1:0]    req_penalty,
   input  wire logic                              req_no_ban,
   // Result channel
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic                                   rsp_found,
   output logic                                   rsp_newly_disconnect,
   output logic                                   rsp_disconnect_status,
   output logic [pmst_pkg::SCORE_W-1:0]           rsp_score,
   output logic [pmst_pkg::UNC_W-1:0]             rsp_unconnecting_count,
   // Configuration port
   input  wire logic                              psel,
   input  wire logic                              penable,
   input  wire logic                              pwrite,
   input  wire logic [pmst_pkg::CSR_ADDR_W-1:0]   paddr,
   input  wire logic [pmst_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [pmst_pkg::CSR_DATA_W-1:0]        prdata,
   output logic                                   pready
);
   import pmst_pkg::*;

   // Slots past the peer field's reach can never be addressed
   localparam int DEPTH = (PEER_SLOTS < PEER_SPACE) ? PEER_SLOTS : PEER_SPACE;

   logic [SCORE_W-1:0]    threshold_ff;
   logic [UNC_W-1:0]      unc_limit_ff;
   logic [PENALTY_W-1:0]  unc_penalty_ff;
   logic                  csr_wr;
   logic [1:0]            csr_idx;
   cfg_type               cfg;
   logic                  cmd_valid;
   cmd_type               cmd_data;
   logic                  cmd_pop;

   // Configuration registers
   assign pready  = 1'b1;
   assign csr_idx = paddr[3:2];
   assign csr_wr  = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff   <= THRESHOLD_RST;
         unc_limit_ff   <= UNC_LIMIT_RST;
         unc_penalty_ff <= UNC_PENALTY_RST;
      end else if (csr_wr) begin
         unique case (csr_idx)
            CSR_THRESHOLD:   threshold_ff   <= pwdata[SCORE_W-1:0];
            CSR_UNC_LIMIT:   unc_limit_ff   <= pwdata[UNC_W-1:0];
            CSR_UNC_PENALTY: unc_penalty_ff <= pwdata[PENALTY_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Register readback
   always_comb begin
      unique case (csr_idx)
         CSR_THRESHOLD:   prdata = CSR_DATA_W'(threshold_ff);
         CSR_UNC_LIMIT:   prdata = CSR_DATA_W'(unc_limit_ff);
         CSR_UNC_PENALTY: prdata = CSR_DATA_W'(unc_penalty_ff);
         default:         prdata = '0;
      endcase
   end

   assign cfg.threshold   = threshold_ff;
   assign cfg.unc_limit   = unc_limit_ff;
   assign cfg.unc_penalty = unc_penalty_ff;

   // Front: accept, classify, queue
   pmst_front #(
      .DEPTH (DEPTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_mode    (req_mode),
      .req_peer    (req_peer),
      .req_penalty (req_penalty),
      .req_no_ban  (req_no_ban),
      .cmd_valid   (cmd_valid),
      .cmd_data    (cmd_data),
      .cmd_pop     (cmd_pop)
   );

   // Back: table read-modify-write and result register
   pmst_back #(
      .DEPTH (DEPTH)
   ) u_back (
      .clock                  (clock),
      .reset                  (reset),
      .cfg                    (cfg),
      .cmd_valid              (cmd_valid),
      .cmd_data               (cmd_data),
      .cmd_pop                (cmd_pop),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_found              (rsp_found),
      .rsp_newly_disconnect   (rsp_newly_disconnect),
      .rsp_disconnect_status  (rsp_disconnect_status),
      .rsp_score              (rsp_score),
      .rsp_unconnecting_count (rsp_unconnecting_count)
   );

endmodule

`default_nettype wire

@@ design/pmst_front.sv @@
// ----------------------------------------------------------------------------
// pmst_front
// Accepts request beats, classifies them into table operations and holds
// them in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module pmst_front #(
   parameter int DEPTH = 64
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic [pmst_pkg::MODE_W-1:0]  req_mode,
   input  wire logic [pmst_pkg::PEER_W-1:0]  req_peer,
   input  wire logic [pmst_pkg::PENALTY_W-1:0] req_penalty,
   input  wire logic                         req_no_ban,
   output logic                              cmd_valid,
   output pmst_pkg::cmd_type                 cmd_data,
   input  wire logic                         cmd_pop
);
   import pmst_pkg::*;

   cmd_type     q_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;
   cmd_type     cls;
   logic        in_range;
   logic        push;

   // Slot index check against the table depth
   assign in_range = ({1'b0, req_peer} < (PEER_W+1)'(DEPTH));

   // Classify the incoming beat
   always_comb begin
      cls.peer    = req_peer;
      cls.penalty = req_penalty;
      cls.no_ban  = req_no_ban;
      if (!in_range) begin
         cls.op = OP_NONE;
      end else begin
         unique case (req_mode)
            MODE_REPORT:  cls.op = OP_REPORT;
            MODE_UNC_INC: cls.op = OP_UNC_INC;
            MODE_UNC_RST: cls.op = OP_UNC_RST;
            MODE_ATTACH:  cls.op = OP_ATTACH;
            MODE_DETACH:  cls.op = OP_DETACH;
            default:      cls.op = OP_QUERY;   // query and unused codes
         endcase
      end
   end

   assign req_ready = (count_ff != 2'd2);
   assign push      = req_valid && req_ready;
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd_data  = q_ff[rd_ptr_ff];

   // Queue pointers
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = cmd_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(cmd_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= cls;
      end
   end

endmodule

`default_nettype wire

@@ design/pmst_back.sv @@
// ----------------------------------------------------------------------------
// pmst_back
// Executes queued operations as a read-modify-write on the slot table and
// holds the result beat in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pmst_back #(
   parameter int DEPTH = 64
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire pmst_pkg::cfg_type             cfg,
   input  wire logic                          cmd_valid,
   input  wire pmst_pkg::cmd_type             cmd_data,
   output logic                               cmd_pop,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic                               rsp_found,
   output logic                               rsp_newly_disconnect,
   output logic                               rsp_disconnect_status,
   output logic [pmst_pkg::SCORE_W-1:0]       rsp_score,
   output logic [pmst_pkg::UNC_W-1:0]         rsp_unconnecting_count
);
   import pmst_pkg::*;

   localparam int IDX_W = $clog2(DEPTH);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EXEC = 1'b1;

   logic                 state_ff, state_in;
   cmd_type              cur_ff;
   entry_type            rd_ff;
   entry_type            mem [DEPTH];
   logic [DEPTH-1:0]     valid_ff, valid_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 found_ff, fresh_ff, status_ff;
   logic [SCORE_W-1:0]   score_ff;
   logic [UNC_W-1:0]     unc_ff;

   logic [IDX_W-1:0]     rd_idx;
   logic [IDX_W-1:0]     cur_idx;
   logic                 retire;
   logic                 found;
   logic                 mem_we;
   entry_type            wr_entry;
   logic                 res_fresh, res_status;
   logic [SCORE_W-1:0]   res_score;
   logic [UNC_W-1:0]     res_unc;

   assign rd_idx  = cmd_data.peer[IDX_W-1:0];
   assign cur_idx = cur_ff.peer[IDX_W-1:0];

   // Pop and read in idle, finish once the output register is free
   assign cmd_pop = (state_ff == ST_IDLE) && cmd_valid;
   assign retire  = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_ready);
   assign found   = (cur_ff.op != OP_NONE) && valid_ff[cur_idx];

   // Entry update
   always_comb begin
      entry_type           e;
      logic [UNC_W-1:0]    unc_inc;
      logic [SCORE_W-1:0]  pts;
      logic [SCORE_W:0]    sum;
      logic [SCORE_W-1:0]  after;
      logic                crossed;
      logic                do_add;

      e        = rd_ff;
      unc_inc  = (rd_ff.unconnecting == {UNC_W{1'b1}}) ? rd_ff.unconnecting
                                                      : rd_ff.unconnecting + UNC_W'(1);
      pts      = (cur_ff.op == OP_REPORT) ? SCORE_W'(cur_ff.penalty)
                                         : SCORE_W'(cfg.unc_penalty);
      sum      = {1'b0, rd_ff.score} + {1'b0, pts};
      after    = sum[SCORE_W] ? {SCORE_W{1'b1}} : sum[SCORE_W-1:0];
      crossed  = (after >= cfg.threshold) && (rd_ff.score < cfg.threshold);
      do_add   = 1'b0;
      res_fresh = 1'b0;
      mem_we   = 1'b0;
      valid_in = valid_ff;

      unique case (cur_ff.op)
         OP_ATTACH: begin
            e          = '0;
            e.no_ban   = cur_ff.no_ban;
            mem_we     = 1'b1;
            valid_in[cur_idx] = 1'b1;
         end
         OP_DETACH: begin
            valid_in[cur_idx] = 1'b0;
         end
         OP_REPORT: begin
            do_add = 1'b1;
            mem_we = found;
         end
         OP_UNC_INC: begin
            if (!rd_ff.latch) begin
               e.unconnecting = unc_inc;
               if (unc_inc >= cfg.unc_limit) begin
                  e.latch = 1'b1;
                  do_add  = 1'b1;
               end
            end
            mem_we = found;
         end
         OP_UNC_RST: begin
            e.unconnecting = '0;
            mem_we         = found;
         end
         OP_QUERY, OP_NONE: begin
         end
         default: begin
         end
      endcase

      // Saturating penalty add with threshold crossing
      if (do_add) begin
         e.score = after;
         if (crossed && !rd_ff.no_ban) begin
            e.discourage = 1'b1;
            res_fresh    = 1'b1;
         end
      end

      wr_entry = e;

      // Result fields are zero unless the slot is shown
      if (cur_ff.op == OP_ATTACH || (found && cur_ff.op != OP_DETACH)) begin
         res_status = e.discourage && !e.no_ban;
         res_score  = e.score;
         res_unc    = e.unconnecting;
      end else begin
         res_fresh  = 1'b0;
         res_status = 1'b0;
         res_score  = '0;
         res_unc    = '0;
      end

      if (!retire) begin
         mem_we   = 1'b0;
         valid_in = valid_ff;
      end
   end

   // Sequencer and output valid
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_IDLE: if (cmd_valid) state_in = ST_EXEC;
         ST_EXEC: begin
            if (retire) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         valid_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         valid_ff     <= valid_in;
      end
   end

   // Command and result payload
   always_ff @(posedge clock) begin
      if (cmd_pop) begin
         cur_ff <= cmd_data;
      end
      if (retire) begin
         found_ff  <= found;
         fresh_ff  <= res_fresh;
         status_ff <= res_status;
         score_ff  <= res_score;
         unc_ff    <= res_unc;
      end
   end

   // Slot table
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[cur_idx] <= wr_entry;
      end
      if (cmd_pop) begin
         rd_ff <= mem[rd_idx];
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_found              = found_ff;
   assign rsp_newly_disconnect   = fresh_ff;
   assign rsp_disconnect_status  = status_ff;
   assign rsp_score              = score_ff;
   assign rsp_unconnecting_count = unc_ff;

endmodule

`default_nettype wire

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the peer misbehavior score table. A clocked driver
// sends request beats in random bursts from a queue that the stimulus
// sequence fills. A local copy of the slot table predicts every answer at the
// edge its request is accepted. A clocked monitor takes answers under a
// random stall pattern, with two long hold-offs to back the block up, and
// checks each one against the oldest prediction. The run steps through
// several register settings, written over APB only while the block is idle.
// ----------------------------------------------------------------------------
module tb_top;
   import pmst_pkg::*;

   localparam int PEER_SLOTS  = 64;
   localparam int STALL_LIMIT = 5000;   // cycles with no beat on either side
   localparam int SETTLE      = 8;      // cycles of quiet before a CSR write
   localparam int HOLD_CYCLES = 300;    // long receiver hold-off

   // Spare mode codes, handled as a query
   localparam logic [MODE_W-1:0] MODE_SPARE6 = 3'd6;
   localparam logic [MODE_W-1:0] MODE_SPARE7 = 3'd7;

   typedef enum {MIX_NORMAL, MIX_REPORT, MIX_UNC} mix_type;

   typedef struct {
      logic [MODE_W-1:0]    mode;
      logic [PEER_W-1:0]    peer;
      logic [PENALTY_W-1:0] penalty;
      logic                 no_ban;
   } req_beat_type;

   typedef struct {
      logic               found;
      logic               newly_disconnect;
      logic               disconnect_status;
      logic [SCORE_W-1:0] score;
      logic [UNC_W-1:0]   unc_count;
   } rsp_beat_type;

   // DUT signals
   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [MODE_W-1:0]     req_mode = '0;
   logic [PEER_W-1:0]     req_peer = '0;
   logic [PENALTY_W-1:0]  req_penalty = '0;
   logic                  req_no_ban = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic                  rsp_found;
   logic                  rsp_newly_disconnect;
   logic                  rsp_disconnect_status;
   logic [SCORE_W-1:0]    rsp_score;
   logic [UNC_W-1:0]      rsp_unconnecting_count;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   peer_misbehavior_score_table #(.PEER_SLOTS(PEER_SLOTS)) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_mode(req_mode),
      .req_peer(req_peer), .req_penalty(req_penalty), .req_no_ban(req_no_ban),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_found(rsp_found),
      .rsp_newly_disconnect(rsp_newly_disconnect),
      .rsp_disconnect_status(rsp_disconnect_status), .rsp_score(rsp_score),
      .rsp_unconnecting_count(rsp_unconnecting_count),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   // Local copy of the slot table and the settings
   bit                 peer_on    [PEER_SLOTS];
   bit                 peer_noban [PEER_SLOTS];
   logic [SCORE_W-1:0] peer_score [PEER_SLOTS];
   bit                 peer_mark  [PEER_SLOTS];
   logic [UNC_W-1:0]   peer_unc   [PEER_SLOTS];
   bit                 peer_latch [PEER_SLOTS];
   logic [SCORE_W-1:0]   thr_cfg   = THRESHOLD_RST;
   logic [UNC_W-1:0]     limit_cfg = UNC_LIMIT_RST;
   logic [PENALTY_W-1:0] unc_pen_cfg = UNC_PENALTY_RST;

   req_beat_type pending_requests[$];
   rsp_beat_type expected_answers[$];
   int n_queued  = 0;
   int n_checked = 0;
   int errors    = 0;

   // Sender and receiver pacing
   int burst_left = 0;
   int gap_left   = 0;
   int seg_left   = 0;
   int seg_kind   = 0;
   int hold_left  = 0;
   int quiet_cycles = 0;

   initial begin
      forever #10 clock = ~clock;
   end

   // Adds points to a slot; returns 1 when this marked the peer
   function automatic bit add_points(int s, logic [PENALTY_W-1:0] pts);
      logic [SCORE_W:0]   sum;
      logic [SCORE_W-1:0] was;
      logic [SCORE_W-1:0] now;
      was = peer_score[s];
      sum = {1'b0, was} + (SCORE_W+1)'(pts);
      now = sum[SCORE_W] ? {SCORE_W{1'b1}} : sum[SCORE_W-1:0];
      peer_score[s] = now;
      if (now >= thr_cfg && was < thr_cfg && !peer_noban[s]) begin
         peer_mark[s] = 1'b1;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // Applies one request to the local table and returns the answer
   function automatic rsp_beat_type predict_answer(req_beat_type b);
      rsp_beat_type a;
      int  s;
      bit  show;
      bit  fresh;
      a = '{default: '0};
      s = int'(b.peer);
      show = 1'b0;
      fresh = 1'b0;
      if (s >= PEER_SLOTS) return a;
      a.found = peer_on[s];
      case (b.mode)
         MODE_ATTACH: begin
            peer_on[s]    = 1'b1;
            peer_noban[s] = b.no_ban;
            peer_score[s] = '0;
            peer_mark[s]  = 1'b0;
            peer_unc[s]   = '0;
            peer_latch[s] = 1'b0;
            show = 1'b1;
         end
         MODE_DETACH: peer_on[s] = 1'b0;
         default: begin
            if (a.found) begin
               show = 1'b1;
               case (b.mode)
                  MODE_REPORT: fresh = add_points(s, b.penalty);
                  MODE_UNC_INC: begin
                     if (!peer_latch[s]) begin
                        if (peer_unc[s] != {UNC_W{1'b1}}) peer_unc[s] = peer_unc[s] + UNC_W'(1);
                        if (peer_unc[s] >= limit_cfg) begin
                           peer_latch[s] = 1'b1;
                           fresh = add_points(s, unc_pen_cfg);
                        end
                     end
                  end
                  MODE_UNC_RST: peer_unc[s] = '0;
                  default: ;   // query and spare codes
               endcase
            end
         end
      endcase
      if (show) begin
         a.newly_disconnect  = fresh;
         a.disconnect_status = peer_mark[s] && !peer_noban[s];
         a.score             = peer_score[s];
         a.unc_count         = peer_unc[s];
      end
      return a;
   endfunction

   // Random request shaped by the phase mix; most hit a few hot peers
   function automatic req_beat_type make_beat(mix_type mix, int span);
      req_beat_type b;
      int r;
      r = $urandom_range(0, 99);
      case (mix)
         MIX_REPORT:
            b.mode = (r < 80) ? MODE_REPORT : (r < 90) ? MODE_UNC_INC :
                     (r < 97) ? MODE_QUERY : MODE_SPARE7;
         MIX_UNC:
            b.mode = (r < 90) ? MODE_UNC_INC : (r < 95) ? MODE_QUERY : MODE_REPORT;
         default:
            b.mode = (r < 30) ? MODE_REPORT : (r < 55) ? MODE_UNC_INC :
                     (r < 63) ? MODE_UNC_RST : (r < 73) ? MODE_QUERY :
                     (r < 85) ? MODE_ATTACH : (r < 92) ? MODE_DETACH :
                     (r < 96) ? MODE_SPARE6 : MODE_SPARE7;
      endcase
      if ($urandom_range(0, 9) == 0) b.peer = PEER_W'($urandom_range(0, PEER_SLOTS - 1));
      else b.peer = PEER_W'($urandom_range(0, span - 1));
      r = $urandom_range(0, 99);
      if (mix == MIX_REPORT && r < 75) b.penalty = {PENALTY_W{1'b1}};
      else if (r < 50) b.penalty = PENALTY_W'($urandom_range(0, 31));
      else if (r < 80) b.penalty = PENALTY_W'($urandom_range(0, 1023));
      else b.penalty = r[0] ? {PENALTY_W{1'b1}} : '0;
      b.no_ban = 1'($urandom_range(0, 1));
      return b;
   endfunction

   task automatic push_beat(logic [MODE_W-1:0] mode, int peer, int pts, bit nb);
      req_beat_type b;
      b.mode = mode;
      b.peer = PEER_W'(peer);
      b.penalty = PENALTY_W'(pts);
      b.no_ban = nb;
      pending_requests.push_back(b);
      n_queued++;
   endtask

   // APB write, then a read back of the same register
   task automatic csr_write(logic [1:0] idx, logic [CSR_DATA_W-1:0] value);
      logic [CSR_DATA_W-1:0] want;
      case (idx)
         CSR_THRESHOLD: begin
            want = value & 32'h0000_FFFF;
            thr_cfg = want[SCORE_W-1:0];
         end
         CSR_UNC_LIMIT: begin
            want = value & 32'h0000_00FF;
            limit_cfg = want[UNC_W-1:0];
         end
         default: begin
            want = value & 32'h0000_03FF;
            unc_pen_cfg = want[PENALTY_W-1:0];
         end
      endcase
      @(posedge clock);
      psel    <= 1'b1;
      pwrite  <= 1'b1;
      penable <= 1'b0;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      pwrite  <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== want) begin
         $display("%0t csr %0d read back: expected %h, actual %h", $time, idx, want, prdata);
         errors++;
      end
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic wait_idle();
      while (n_checked != n_queued) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // One setting of the registers followed by a run of random requests
   task automatic run_phase(logic [CSR_DATA_W-1:0] thr, logic [CSR_DATA_W-1:0] lim,
                            logic [CSR_DATA_W-1:0] pen, mix_type mix, int span,
                            int count);
      wait_idle();
      csr_write(CSR_THRESHOLD, thr);
      csr_write(CSR_UNC_LIMIT, lim);
      csr_write(CSR_UNC_PENALTY, pen);
      for (int i = 0; i < span; i++) push_beat(MODE_ATTACH, i, $urandom_range(0, 1023),
                                               1'($urandom_range(0, 1)));
      for (int i = 0; i < count; i++) begin
         pending_requests.push_back(make_beat(mix, span));
         n_queued++;
      end
   endtask

   // Main sequence
   initial begin
      for (int i = 0; i < PEER_SLOTS; i++) begin
         peer_on[i] = 0; peer_noban[i] = 0; peer_score[i] = '0;
         peer_mark[i] = 0; peer_unc[i] = '0; peer_latch[i] = 0;
      end
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed: absent peers, exact crossing, no-ban crossing, re-attach
      push_beat(MODE_REPORT, 0, 1023, 1);
      push_beat(MODE_QUERY, 0, 0, 0);
      push_beat(MODE_DETACH, 0, 0, 0);
      push_beat(MODE_ATTACH, 0, 1023, 0);
      push_beat(MODE_ATTACH, 63, 0, 1);
      push_beat(MODE_REPORT, 0, 0, 0);
      push_beat(MODE_REPORT, 0, 99, 0);
      push_beat(MODE_REPORT, 0, 1, 1);
      push_beat(MODE_REPORT, 0, 1023, 0);
      push_beat(MODE_REPORT, 63, 1023, 0);
      push_beat(MODE_QUERY, 63, 1023, 1);
      push_beat(MODE_UNC_INC, 0, 0, 0);
      push_beat(MODE_UNC_INC, 0, 0, 1);
      push_beat(MODE_UNC_INC, 0, 1023, 0);
      push_beat(MODE_UNC_RST, 0, 0, 0);
      push_beat(MODE_SPARE6, 0, 0, 0);
      push_beat(MODE_SPARE7, 63, 1023, 1);
      push_beat(MODE_ATTACH, 0, 0, 1);
      push_beat(MODE_UNC_RST, 63, 0, 0);
      push_beat(MODE_DETACH, 63, 0, 0);
      push_beat(MODE_QUERY, 63, 0, 0);
      push_beat(MODE_UNC_INC, 63, 0, 0);
      push_beat(MODE_REPORT, 0, 1023, 0);
      push_beat(MODE_DETACH, 0, 0, 1);

      // Zero threshold, limit of one
      run_phase(0, 1, 0, MIX_NORMAL, 6, 240);
      // Top threshold, score saturation
      run_phase(32'h0000_FFFF, 255, 1023, MIX_REPORT, 2, 220);
      // Count runs up to the top limit
      run_phase(300, 255, 1023, MIX_UNC, 1, 340);
      // Zero limit
      run_phase($urandom_range(0, 2000), 0, $urandom_range(0, 1023), MIX_NORMAL, 8, 220);
      // Back to the reset values
      run_phase(THRESHOLD_RST, UNC_LIMIT_RST, UNC_PENALTY_RST, MIX_NORMAL, 8, 240);
      // Full-width random writes; upper bits are dropped
      run_phase($urandom(),
                CSR_DATA_W'({$urandom_range(0, 16'hFFFF), 8'd0} | $urandom_range(1, 255)),
                $urandom(), MIX_NORMAL, 12, 220);
      run_phase($urandom_range(0, 500), $urandom_range(2, 5), $urandom_range(0, 1023),
                MIX_NORMAL, 4, 240);
      run_phase(1, 3, 1023, MIX_REPORT, 3, 200);

      wait_idle();
      repeat (20) @(posedge clock);
      if (expected_answers.size() != 0) begin
         $display("%0t %0d answers never arrived", $time, expected_answers.size());
         errors++;
      end
      if (errors == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

   // Driver: predict on acceptance, then offer the next beat or idle
   always @(posedge clock) begin
      req_beat_type b;
      bit           took;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         took = req_valid && req_ready;
         if (took) begin
            b.mode = req_mode;
            b.peer = req_peer;
            b.penalty = req_penalty;
            b.no_ban = req_no_ban;
            expected_answers.push_back(predict_answer(b));
         end
         if (!req_valid || took) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_requests.size() > 0) begin
               b = pending_requests.pop_front();
               req_mode    <= b.mode;
               req_peer    <= b.peer;
               req_penalty <= b.penalty;
               req_no_ban  <= b.no_ban;
               req_valid   <= 1'b1;
               if (burst_left > 0) burst_left--;
               if (burst_left == 0) begin
                  if ($urandom_range(0, 7) == 0) begin
                     burst_left = 100;
                     gap_left = 0;
                  end else begin
                     burst_left = $urandom_range(1, 24);
                     gap_left = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 8);
                  end
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
         $display("%0t %s: expected %0d, actual %0d", $time, name, want, got);
         errors++;
      end
   endtask

   // Monitor: check answers, then pick the next ready level
   always @(posedge clock) begin
      rsp_beat_type want;
      bit           rdy;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_answers.size() == 0) begin
               $display("%0t answer with none expected: score %0d", $time, rsp_score);
               errors++;
            end else begin
               want = expected_answers.pop_front();
               check_field("found", 16'(want.found), 16'(rsp_found));
               check_field("newly_disconnect", 16'(want.newly_disconnect),
                           16'(rsp_newly_disconnect));
               check_field("disconnect_status", 16'(want.disconnect_status),
                           16'(rsp_disconnect_status));
               check_field("score", want.score, rsp_score);
               check_field("unconnecting_count", 16'(want.unc_count),
                           16'(rsp_unconnecting_count));
            end
            n_checked++;
            // Long hold-off so the block fills and stalls its input
            if (n_checked == 400 || n_checked == 1300) hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rdy = 1'b0;
         end else begin
            if (seg_left == 0) begin
               seg_kind = $urandom_range(0, 3);
               seg_left = $urandom_range(5, 60);
            end
            seg_left--;
            case (seg_kind)
               0: rdy = 1'b1;
               1: rdy = ($urandom_range(0, 3) != 0);
               2: rdy = ($urandom_range(0, 3) == 0);
               default: rdy = seg_left[0];
            endcase
         end
         rsp_ready <= rdy;
      end
   end

   // Watchdog on cycles with no beat on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles + 1 >= STALL_LIMIT) begin
            $display("%0t no beat for %0d cycles", $time, STALL_LIMIT);
            $display("tb_top NOT OK");
            $finish;
         end
      end
   end

endmodule

@@ filelist.f @@
design/pmst_pkg.sv
design/pmst_front.sv
design/pmst_back.sv
design/peer_misbehavior_score_table.sv
tb/sv/tb_top.sv
